// ===== rtl/core/cht_pkg.sv =====
`default_nettype none

package cht_pkg;

   // command field codes
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_PRESENT  = 3'd1,
      ST_FULL     = 3'd2,
      ST_FOUND    = 3'd3,
      ST_MISSING  = 3'd4,
      ST_REMOVED  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      SLOT_ZERO = 2'd0,
      SLOT_CUR  = 2'd1,
      SLOT_FP   = 2'd2
   } slot_sel_type;

   typedef enum logic [1:0] {
      RD_NONE = 2'd0,
      RD_CUR  = 2'd1,
      RD_FP   = 2'd2,
      RD_LINK = 2'd3
   } rd_op_type;

   typedef enum logic [3:0] {
      WR_NONE        = 4'd0,
      WR_KEY_AT_CUR  = 4'd1,
      WR_KEY_AT_FP   = 4'd2,
      WR_LINK_CUR_FP = 4'd3,
      WR_CLEAR_CUR   = 4'd4,
      WR_PULL_CUR    = 4'd5,
      WR_FREE_AUX    = 4'd6,
      WR_LINK_PREV   = 4'd7,
      WR_FREE_CUR    = 4'd8,
      WR_SWEEP       = 4'd9
   } wr_op_type;

   typedef enum logic [3:0] {
      S_CLEAR     = 4'd0,
      S_IDLE      = 4'd1,
      S_HOME      = 4'd2,
      S_RD        = 4'd3,
      S_CHK       = 4'd4,
      S_RM_PULL   = 4'd5,
      S_RM_FREE   = 4'd6,
      S_RM_UNLINK = 4'd7,
      S_FREE_RD   = 4'd8,
      S_FREE_CHK  = 4'd9,
      S_LINK      = 4'd10,
      S_FIN       = 4'd11
   } ctrl_state_type;

   typedef struct packed {
      logic         load;
      logic         start_walk;
      logic         walk_step;
      logic         fp_dec;
      logic         sweep_step;
      rd_op_type    rd_op;
      wr_op_type    wr_op;
      logic         set_result;
      status_type   res_code;
      slot_sel_type res_slot;
      logic         rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic   home_done;
      logic   key_zero;
      op_type op;
      logic   hit;
      logic   link_ok;
      logic   walk_max;
      logic   rd_key_zero;
      logic   fp_valid;
      logic   at_home;
      logic   prev_valid;
      logic   sweep_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/cht_home.sv =====
`default_nettype none

// home slot = key mod SLOTS; mask for a power of two, else 16-bit chunk residues are
// summed and the sum is reduced by reciprocal multiplication
module cht_home #(
   parameter int SLOTS    = 8,
   parameter int KEY_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [KEY_BITS-1:0]      key,
   output logic                          done,
   output logic [$clog2(SLOTS)-1:0]      home
);

   localparam int IDX_W = $clog2(SLOTS);

   generate
      if ((SLOTS & (SLOTS - 1)) == 0) begin : g_mask
         logic             done_ff, done_in;
         logic [IDX_W-1:0] rem_ff, rem_in;

         always_comb begin
            done_in = start;
            rem_in  = start ? key[IDX_W-1:0] : rem_ff;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= done_in;
            end
            rem_ff <= rem_in;
         end

         assign done = done_ff;
         assign home = rem_ff;
      end else begin : g_fold
         localparam int NCH   = (KEY_BITS + 15) / 16;
         localparam int SUM_W = 16 + IDX_W + $clog2(NCH);
         localparam int SH    = SUM_W + IDX_W;
         localparam int QW    = SUM_W - IDX_W + 1;
         localparam int PW    = 2 * SUM_W + 1;
         // ceil(2^SH / SLOTS); exact quotient for any sum below 2^SUM_W
         localparam logic [63:0] RCP_L =
            ((64'd1 << SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
         localparam logic [SUM_W:0] RCP = RCP_L[SUM_W:0];

         logic [NCH*16-1:0] key_ext;
         logic [SUM_W-1:0]  term [NCH];
         logic [PW-1:0]     prod;
         logic [SUM_W-1:0]  qm;
         logic              s1_ff, s1_in;
         logic              s2_ff, s2_in;
         logic              done_ff, done_in;
         logic [SUM_W-1:0]  sum_ff, sum_in;
         logic [QW-1:0]     q_ff, q_in;
         logic [IDX_W-1:0]  rem_ff, rem_in;

         assign key_ext = (NCH * 16)'(key);

         // chunk i weighs 2^(16i) mod SLOTS
         for (genvar i = 0; i < NCH; i++) begin : g_term
            localparam logic [63:0] RES_L = (64'd1 << (16 * i)) % 64'(SLOTS);
            assign term[i] = SUM_W'(key_ext[16*i +: 16]) * SUM_W'(RES_L[IDX_W-1:0]);
         end

         always_comb begin
            s1_in   = start;
            s2_in   = s1_ff;
            done_in = s2_ff;
            sum_in  = sum_ff;
            q_in    = q_ff;
            rem_in  = rem_ff;
            prod    = PW'(sum_ff) * PW'(RCP);
            qm      = SUM_W'(q_ff) * SUM_W'(SLOTS);
            if (start) begin
               sum_in = '0;
               for (int i = 0; i < NCH; i++) begin
                  sum_in = sum_in + term[i];
               end
            end
            if (s1_ff) begin
               q_in = prod[SH +: QW];
            end
            if (s2_ff) begin
               rem_in = IDX_W'(sum_ff - qm);
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               s1_ff   <= 1'b0;
               s2_ff   <= 1'b0;
               done_ff <= 1'b0;
            end else begin
               s1_ff   <= s1_in;
               s2_ff   <= s2_in;
               done_ff <= done_in;
            end
            sum_ff <= sum_in;
            q_ff   <= q_in;
            rem_ff <= rem_in;
         end

         assign done = done_ff;
         assign home = rem_ff;
      end
   endgenerate

endmodule

`default_nettype wire

// ===== rtl/core/cht_datapath.sv =====
`default_nettype none

module cht_datapath import cht_pkg::*; #(
   parameter int SLOTS    = 8,
   parameter int KEY_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire dp_cmd_type               cmd,
   output dp_status_type                 st,
   input  wire logic [1:0]               req_cmd,
   input  wire logic [KEY_BITS-1:0]      req_key,
   output logic [2:0]                    rsp_status,
   output logic [$clog2(SLOTS)-1:0]      rsp_slot,
   output logic                          rsp_table_empty
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [IDX_W:0] NO_LINK = '0;   // msb is the link-valid flag

   // slot store
   logic [KEY_BITS-1:0] keys_mem  [SLOTS];
   logic [IDX_W:0]      links_mem [SLOTS];

   logic [KEY_BITS-1:0] key_ff, key_in;
   op_type              op_ff, op_in;
   logic [IDX_W-1:0]    cur_ff, cur_in;
   logic [IDX_W-1:0]    prev_ff, prev_in;
   logic                prev_valid_ff, prev_valid_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [IDX_W-1:0]    aux_ff, aux_in;
   logic [IDX_W-1:0]    fp_ff, fp_in;
   logic                fp_valid_ff, fp_valid_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    sweep_ff, sweep_in;
   logic [KEY_BITS-1:0] rd_key_ff;
   logic [IDX_W:0]      rd_link_ff;
   status_type          res_status_ff, res_status_in;
   logic [IDX_W-1:0]    res_slot_ff, res_slot_in;
   logic [2:0]          rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic                rsp_empty_ff, rsp_empty_in;

   logic                home_done;
   logic [IDX_W-1:0]    home;

   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic                key_we, link_we;
   logic [IDX_W-1:0]    key_wa, link_wa;
   logic [KEY_BITS-1:0] key_wd;
   logic [IDX_W:0]      link_wd;
   logic                raise_en;
   logic [IDX_W-1:0]    raise_slot;
   logic                cnt_up, cnt_dn;

   cht_home #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS)
   ) u_home (
      .clock (clock),
      .reset (reset),
      .start (cmd.load),
      .key   (req_key),
      .done  (home_done),
      .home  (home)
   );

   // read port
   always_comb begin
      rd_en   = 1'b1;
      rd_addr = cur_ff;
      case (cmd.rd_op)
         RD_CUR:  rd_addr = cur_ff;
         RD_FP:   rd_addr = fp_ff;
         RD_LINK: rd_addr = rd_link_ff[IDX_W-1:0];
         default: rd_en   = 1'b0;
      endcase
   end

   // write port decode
   always_comb begin
      key_we     = 1'b0;
      key_wa     = cur_ff;
      key_wd     = '0;
      link_we    = 1'b0;
      link_wa    = cur_ff;
      link_wd    = NO_LINK;
      raise_en   = 1'b0;
      raise_slot = cur_ff;
      cnt_up     = 1'b0;
      cnt_dn     = 1'b0;
      case (cmd.wr_op)
         WR_KEY_AT_CUR: begin
            key_we = 1'b1;
            key_wd = key_ff;
            cnt_up = 1'b1;
         end
         WR_KEY_AT_FP: begin
            key_we = 1'b1;
            key_wa = fp_ff;
            key_wd = key_ff;
            cnt_up = 1'b1;
         end
         WR_LINK_CUR_FP: begin
            link_we = 1'b1;
            link_wd = {1'b1, fp_ff};
         end
         WR_CLEAR_CUR: begin
            key_we   = 1'b1;
            raise_en = 1'b1;
            cnt_dn   = 1'b1;
         end
         WR_PULL_CUR: begin
            key_we  = 1'b1;
            key_wd  = rd_key_ff;
            link_we = 1'b1;
            link_wd = rd_link_ff;
         end
         WR_FREE_AUX: begin
            key_we     = 1'b1;
            key_wa     = aux_ff;
            link_we    = 1'b1;
            link_wa    = aux_ff;
            raise_en   = 1'b1;
            raise_slot = aux_ff;
            cnt_dn     = 1'b1;
         end
         WR_LINK_PREV: begin
            link_we = 1'b1;
            link_wa = prev_ff;
            link_wd = rd_link_ff;
         end
         WR_FREE_CUR: begin
            key_we   = 1'b1;
            link_we  = 1'b1;
            raise_en = 1'b1;
            cnt_dn   = 1'b1;
         end
         WR_SWEEP: begin
            key_we  = 1'b1;
            key_wa  = sweep_ff;
            link_we = 1'b1;
            link_wa = sweep_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         keys_mem[key_wa] <= key_wd;
      end
      if (link_we) begin
         links_mem[link_wa] <= link_wd;
      end
      if (rd_en) begin
         rd_key_ff  <= keys_mem[rd_addr];
         rd_link_ff <= links_mem[rd_addr];
      end
   end

   // walk, free pointer, occupancy and result registers
   always_comb begin
      key_in        = key_ff;
      op_in         = op_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      n_in          = n_ff;
      aux_in        = aux_ff;
      fp_in         = fp_ff;
      fp_valid_in   = fp_valid_ff;
      count_in      = count_ff;
      sweep_in      = sweep_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_empty_in  = rsp_empty_ff;

      if (cmd.load) begin
         key_in = req_key;
         case (req_cmd)
            OP_INSERT: op_in = OP_INSERT;
            OP_REMOVE: op_in = OP_REMOVE;
            default:   op_in = OP_SEARCH;   // unused code behaves as search
         endcase
      end

      if (cmd.start_walk) begin
         cur_in        = home;
         n_in          = '0;
         prev_valid_in = 1'b0;
      end else if (cmd.walk_step) begin
         prev_in       = cur_ff;
         prev_valid_in = 1'b1;
         cur_in        = rd_link_ff[IDX_W-1:0];
         n_in          = n_ff + CNT_W'(1);
      end

      if (cmd.rd_op == RD_LINK) begin
         aux_in = rd_link_ff[IDX_W-1:0];
      end

      if (cmd.fp_dec) begin
         if (fp_ff == '0) begin
            fp_valid_in = 1'b0;
         end else begin
            fp_in = fp_ff - IDX_W'(1);
         end
      end else if (raise_en && (!fp_valid_ff || fp_ff < raise_slot)) begin
         fp_in       = raise_slot;
         fp_valid_in = 1'b1;
      end

      if (cnt_up) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cnt_dn) begin
         count_in = count_ff - CNT_W'(1);
      end

      if (cmd.sweep_step) begin
         sweep_in = sweep_ff + IDX_W'(1);
      end

      if (cmd.set_result) begin
         res_status_in = cmd.res_code;
         case (cmd.res_slot)
            SLOT_CUR: res_slot_in = cur_ff;
            SLOT_FP:  res_slot_in = fp_ff;
            default:  res_slot_in = '0;
         endcase
      end

      if (cmd.rsp_load) begin
         rsp_status_in = res_status_ff;
         rsp_slot_in   = res_slot_ff;
         rsp_empty_in  = (count_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fp_ff       <= IDX_W'(SLOTS - 1);
         fp_valid_ff <= 1'b1;
         count_ff    <= '0;
         sweep_ff    <= '0;
      end else begin
         fp_ff       <= fp_in;
         fp_valid_ff <= fp_valid_in;
         count_ff    <= count_in;
         sweep_ff    <= sweep_in;
      end
      key_ff        <= key_in;
      op_ff         <= op_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      prev_valid_ff <= prev_valid_in;
      n_ff          <= n_in;
      aux_ff        <= aux_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   always_comb begin
      st.home_done   = home_done;
      st.key_zero    = (key_ff == '0);
      st.op          = op_ff;
      st.hit         = (rd_key_ff == key_ff);
      st.link_ok     = rd_link_ff[IDX_W];
      st.walk_max    = (n_ff == CNT_W'(SLOTS));
      st.rd_key_zero = (rd_key_ff == '0);
      st.fp_valid    = fp_valid_ff;
      st.at_home     = (cur_ff == home);
      st.prev_valid  = prev_valid_ff;
      st.sweep_last  = (sweep_ff == IDX_W'(SLOTS - 1));
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_table_empty = rsp_empty_ff;

endmodule

`default_nettype wire

// ===== rtl/core/cht_ctrl.sv =====
`default_nettype none

module cht_ctrl import cht_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output dp_cmd_type         cmd,
   input  wire dp_status_type st
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            cmd.wr_op      = WR_SWEEP;
            cmd.sweep_step = 1'b1;
            if (st.sweep_last) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_HOME;
            end
         end

         S_HOME: begin
            if (st.key_zero) begin
               cmd.set_result = 1'b1;
               cmd.res_code   = (st.op == OP_INSERT) ? ST_FULL : ST_MISSING;
               cmd.res_slot   = SLOT_ZERO;
               state_in       = S_FIN;
            end else if (st.home_done) begin
               cmd.start_walk = 1'b1;
               state_in       = S_RD;
            end
         end

         S_RD: begin
            cmd.rd_op = RD_CUR;
            state_in  = S_CHK;
         end

         S_CHK: begin
            if (st.hit) begin
               cmd.set_result = 1'b1;
               cmd.res_slot   = SLOT_CUR;
               state_in       = S_FIN;
               case (st.op)
                  OP_INSERT: cmd.res_code = ST_PRESENT;
                  OP_REMOVE: begin
                     cmd.res_code = ST_REMOVED;
                     if (st.at_home) begin
                        if (st.link_ok) begin
                           cmd.rd_op = RD_LINK;
                           state_in  = S_RM_PULL;
                        end else begin
                           cmd.wr_op = WR_CLEAR_CUR;
                        end
                     end else if (st.prev_valid) begin
                        cmd.wr_op = WR_LINK_PREV;
                        state_in  = S_RM_UNLINK;
                     end
                  end
                  default:   cmd.res_code = ST_FOUND;
               endcase
            end else if (!st.link_ok || st.walk_max) begin
               // miss: cur is now the chain tail
               if (st.op == OP_INSERT) begin
                  if (st.rd_key_zero) begin
                     cmd.wr_op      = WR_KEY_AT_CUR;
                     cmd.set_result = 1'b1;
                     cmd.res_code   = ST_INSERTED;
                     cmd.res_slot   = SLOT_CUR;
                     state_in       = S_FIN;
                  end else begin
                     state_in = S_FREE_RD;
                  end
               end else begin
                  cmd.set_result = 1'b1;
                  cmd.res_code   = ST_MISSING;
                  cmd.res_slot   = SLOT_ZERO;
                  state_in       = S_FIN;
               end
            end else begin
               cmd.walk_step = 1'b1;
               state_in      = S_RD;
            end
         end

         S_RM_PULL: begin
            cmd.wr_op = WR_PULL_CUR;
            state_in  = S_RM_FREE;
         end

         S_RM_FREE: begin
            cmd.wr_op = WR_FREE_AUX;
            state_in  = S_FIN;
         end

         S_RM_UNLINK: begin
            cmd.wr_op = WR_FREE_CUR;
            state_in  = S_FIN;
         end

         S_FREE_RD: begin
            if (st.fp_valid) begin
               cmd.rd_op = RD_FP;
               state_in  = S_FREE_CHK;
            end else begin
               cmd.set_result = 1'b1;
               cmd.res_code   = ST_FULL;
               cmd.res_slot   = SLOT_ZERO;
               state_in       = S_FIN;
            end
         end

         S_FREE_CHK: begin
            if (st.rd_key_zero) begin
               cmd.wr_op      = WR_KEY_AT_FP;
               cmd.set_result = 1'b1;
               cmd.res_code   = ST_INSERTED;
               cmd.res_slot   = SLOT_FP;
               state_in       = S_LINK;
            end else begin
               cmd.fp_dec = 1'b1;
               state_in   = S_FREE_RD;
            end
         end

         S_LINK: begin
            cmd.wr_op = WR_LINK_CUR_FP;
            state_in  = S_FIN;
         end

         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/core/coalesced_hash_table_core.sv =====
`default_nettype none

// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+--------------------------------------
// req      | in        | req_valid/req_ready | req_cmd, req_key
// rsp      | out       | rsp_valid/rsp_ready | rsp_status, rsp_slot, rsp_table_empty
//
// One item at a time. An item is accepted, waits for the home slot unit (a mask when
// SLOTS is a power of two, else a fold), reads and checks each slot visited on the
// chain walk (at most SLOTS+1 visits), reads and tests each slot of the free scan until
// it finds one empty or runs out, makes its writes and loads the result. A zero key
// skips the home slot wait and the walk. The slot store's single read port sets the
// walk and scan pace. After reset a clearing pass over every slot empties the store;
// no item is taken meanwhile. The result sits in an output register, so the next item
// is taken while it waits; a stalled rsp only holds the block in S_FIN of the next item.

module coalesced_hash_table_core import cht_pkg::*; #(
   parameter int SLOTS    = 8,
   parameter int KEY_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_cmd,
   input  wire logic [KEY_BITS-1:0]      req_key,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [2:0]                    rsp_status,
   output logic [$clog2(SLOTS)-1:0]      rsp_slot,
   output logic                          rsp_table_empty
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_st;

   // sequencer: walk, free scan and write order per command
   cht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (dp_cmd),
      .st        (dp_st)
   );

   // slot store, walk registers, free pointer, occupancy count, result registers
   cht_datapath #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .st              (dp_st),
      .req_cmd         (req_cmd),
      .req_key         (req_key),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_table_empty (rsp_table_empty)
   );

endmodule

`default_nettype wire
